// File: rtl/sarmfk_pkg.sv
// shared types, constants and helper functions for the serial arm kinematics block
// no dependencies
package sarmfk_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int STEP_W = $clog2(ATAN_ENTRIES);
   localparam int XW = 34;
   localparam int ZW = 36;
   localparam int PW = 48;
   localparam int FRAMES = 4;

   localparam logic signed [XW-1:0] GAIN_Q30 = XW'(652032874);
   localparam logic signed [ZW-1:0] PI_Q30 = ZW'(64'd3373259426);
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(64'd1686629713);
   localparam logic signed [16:0] PI_Q13 = 17'sd25736;
   localparam logic signed [16:0] TWO_PI_Q13 = 17'sd51472;
   localparam logic signed [19:0] POS_MAX = 20'sd524287;
   localparam logic signed [19:0] POS_MIN = -20'sd524288;
   localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

   typedef enum logic [0:0] {
      CSR_LINK_LENGTH = 1'b0,
      CSR_TOOL_LENGTH = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] yaw_angle;
      logic signed [15:0] first_pitch;
      logic signed [15:0] extension;
      logic signed [15:0] second_pitch;
   } req_type;

   typedef struct packed {
      logic [1:0]         frame;
      logic               is_last;
      logic signed [19:0] pos_x;
      logic signed [19:0] pos_y;
      logic signed [19:0] pos_z;
      logic signed [15:0] cos_yaw;
      logic signed [15:0] sin_yaw;
      logic signed [15:0] cos_pitch;
      logic signed [15:0] sin_pitch;
   } rsp_type;

   // one rotation in flight: yaw, first pitch, pitch sum
   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 neg;
   } lane_type;

   typedef struct packed {
      lane_type [2:0]     lane;
      logic signed [15:0] ext;
   } cell_type;

   typedef struct packed {
      logic signed [19:0] x;
      logic signed [19:0] y;
      logic signed [19:0] z;
   } pos_type;

   typedef struct packed {
      pos_type [FRAMES-1:0] pos;
      logic signed [15:0]   cy;
      logic signed [15:0]   sy;
      logic signed [15:0]   cb;
      logic signed [15:0]   sb;
      logic signed [15:0]   cq;
      logic signed [15:0]   sq;
   } frames_type;

   function automatic logic signed [ZW-1:0] atan_q30(input logic [STEP_W-1:0] idx);
      logic signed [ZW-1:0] r;
      case (idx)
         5'd0:  r = ZW'(843314856);
         5'd1:  r = ZW'(497837829);
         5'd2:  r = ZW'(263043836);
         5'd3:  r = ZW'(133525158);
         5'd4:  r = ZW'(66890614);
         5'd5:  r = ZW'(33543515);
         5'd6:  r = ZW'(16775850);
         5'd7:  r = ZW'(8388437);
         5'd8:  r = ZW'(4194282);
         5'd9:  r = ZW'(2097149);
         5'd10: r = ZW'(1048575);
         5'd11: r = ZW'(524287);
         5'd12: r = ZW'(262143);
         5'd13: r = ZW'(131071);
         5'd14: r = ZW'(65535);
         5'd15: r = ZW'(32767);
         5'd16: r = ZW'(16383);
         5'd17: r = ZW'(8191);
         5'd18: r = ZW'(4095);
         5'd19: r = ZW'(2047);
         5'd20: r = ZW'(1023);
         5'd21: r = ZW'(511);
         5'd22: r = ZW'(255);
         5'd23: r = ZW'(127);
         default: r = '0;
      endcase
      return r;
   endfunction

   // Q3.13 angle to Q30 with a fold by pi into [-pi/2, pi/2]
   function automatic lane_type fold_lane(input logic signed [15:0] ang);
      lane_type r;
      logic signed [ZW-1:0] z;
      z = ZW'(ang) <<< 17;
      r.x = GAIN_Q30;
      r.y = '0;
      r.neg = 1'b0;
      r.z = z;
      if (z > HALF_PI_Q30) begin
         r.z = z - PI_Q30;
         r.neg = 1'b1;
      end else if (z < -HALF_PI_Q30) begin
         r.z = z + PI_Q30;
         r.neg = 1'b1;
      end
      return r;
   endfunction

   function automatic logic signed [15:0] clamp_q14(input logic signed [XW-1:0] v);
      logic signed [XW-1:0] r;
      r = (v + XW'(32768)) >>> 16;
      if (r > XW'(ONE_Q14)) r = XW'(ONE_Q14);
      if (r < -XW'(ONE_Q14)) r = -XW'(ONE_Q14);
      return r[15:0];
   endfunction

   function automatic logic signed [19:0] sat_pos(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] r;
      r = (v + (PW'(1) <<< 27)) >>> 28;
      if (r > PW'(POS_MAX)) r = PW'(POS_MAX);
      if (r < PW'(POS_MIN)) r = PW'(POS_MIN);
      return r[19:0];
   endfunction

endpackage

// File: rtl/sarmfk_cordic_cell.sv
// one rotation step of the cordic chain, applied to three angles at once
// depends on sarmfk_pkg
module sarmfk_cordic_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic [sarmfk_pkg::STEP_W-1:0]  step,
   input  logic                           in_valid,
   input  sarmfk_pkg::cell_type           in_data,
   output logic                           out_valid,
   output sarmfk_pkg::cell_type           out_data
);
   import sarmfk_pkg::*;

   logic     valid_ff;
   cell_type data_ff, data_in;
   logic signed [ZW-1:0] angle;

   always_comb begin
      angle = atan_q30(step);
      data_in = in_data;
      for (int k = 0; k < 3; k++) begin
         if (in_data.lane[k].z >= 0) begin
            data_in.lane[k].x = in_data.lane[k].x - (in_data.lane[k].y >>> step);
            data_in.lane[k].y = in_data.lane[k].y + (in_data.lane[k].x >>> step);
            data_in.lane[k].z = in_data.lane[k].z - angle;
         end else begin
            data_in.lane[k].x = in_data.lane[k].x + (in_data.lane[k].y >>> step);
            data_in.lane[k].y = in_data.lane[k].y - (in_data.lane[k].x >>> step);
            data_in.lane[k].z = in_data.lane[k].z + angle;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: rtl/sarmfk_post.sv
// sign fix, rounding and link geometry after the cordic chain: four register stages
// depends on sarmfk_pkg
module sarmfk_post (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic [15:0]            link_length,
   input  logic [15:0]            tool_length,
   input  logic                   in_valid,
   input  sarmfk_pkg::cell_type   in_data,
   output logic                   out_valid,
   output sarmfk_pkg::frames_type out_data
);
   import sarmfk_pkg::*;

   logic [3:0] valid_ff;

   // stage 1: trig values and link distances
   logic signed [15:0] t_ff [6];
   logic signed [15:0] t_in [6];
   logic signed [18:0] d3_ff, d4_ff;

   // stage 2: trig products
   logic signed [31:0] sbcy_ff, sbsy_ff, sqcy_ff, sqsy_ff;
   logic signed [15:0] t2_ff [6];
   logic signed [18:0] d3b_ff, d4b_ff;

   // stage 3: scaled by lengths
   logic signed [PW-1:0] m3x_ff, m3y_ff, m3z_ff, m4x_ff, m4y_ff, m4z_ff;
   logic signed [PW-1:0] tx_ff, ty_ff, tz_ff;
   logic signed [15:0]   t3_ff [6];

   frames_type out_ff, out_in;
   logic signed [PW-1:0] base_z;
   logic signed [16:0]   tool_s;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         t_in[2*k]   = clamp_q14(in_data.lane[k].neg ? -in_data.lane[k].x : in_data.lane[k].x);
         t_in[2*k+1] = clamp_q14(in_data.lane[k].neg ? -in_data.lane[k].y : in_data.lane[k].y);
      end
   end

   assign tool_s = $signed({1'b0, tool_length});
   assign base_z = $signed({{(PW-16){1'b0}}, link_length}) <<< 28;

   always_comb begin
      out_in.cy = t3_ff[0];
      out_in.sy = t3_ff[1];
      out_in.cb = t3_ff[2];
      out_in.sb = t3_ff[3];
      out_in.cq = t3_ff[4];
      out_in.sq = t3_ff[5];
      out_in.pos[0].x = '0;
      out_in.pos[0].y = '0;
      out_in.pos[0].z = 20'($unsigned(link_length));
      out_in.pos[1].x = sat_pos(m3x_ff);
      out_in.pos[1].y = sat_pos(m3y_ff);
      out_in.pos[1].z = sat_pos(base_z + (m3z_ff <<< 14));
      out_in.pos[2].x = sat_pos(m4x_ff);
      out_in.pos[2].y = sat_pos(m4y_ff);
      out_in.pos[2].z = sat_pos(base_z + (m4z_ff <<< 14));
      out_in.pos[3].x = sat_pos(m4x_ff + tx_ff);
      out_in.pos[3].y = sat_pos(m4y_ff + ty_ff);
      out_in.pos[3].z = sat_pos(base_z + (m4z_ff <<< 14) + (tz_ff <<< 14));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
      if (adv) begin
         t_ff    <= t_in;
         d3_ff   <= 19'($signed({1'b0, link_length})) + 19'(in_data.ext);
         d4_ff   <= (19'($signed({1'b0, link_length})) <<< 1) + 19'(in_data.ext);

         sbcy_ff <= 32'(t_ff[3] * t_ff[0]);
         sbsy_ff <= 32'(t_ff[3] * t_ff[1]);
         sqcy_ff <= 32'(t_ff[5] * t_ff[0]);
         sqsy_ff <= 32'(t_ff[5] * t_ff[1]);
         t2_ff   <= t_ff;
         d3b_ff  <= d3_ff;
         d4b_ff  <= d4_ff;

         m3x_ff  <= PW'(d3b_ff * sbcy_ff);
         m3y_ff  <= PW'(d3b_ff * sbsy_ff);
         m3z_ff  <= PW'(d3b_ff * t2_ff[2]);
         m4x_ff  <= PW'(d4b_ff * sbcy_ff);
         m4y_ff  <= PW'(d4b_ff * sbsy_ff);
         m4z_ff  <= PW'(d4b_ff * t2_ff[2]);
         tx_ff   <= PW'(tool_s * sqcy_ff);
         ty_ff   <= PW'(tool_s * sqsy_ff);
         tz_ff   <= PW'(tool_s * t2_ff[4]);
         t3_ff   <= t2_ff;

         out_ff  <= out_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_data  = out_ff;

endmodule

// File: rtl/serial_arm_forward_kinematics.sv
// top level: input register, cordic cell chain, geometry stages and frame serialiser
// depends on sarmfk_pkg, sarmfk_cordic_cell, sarmfk_post
//
// channel | direction | ports                           | moves
// req     | in        | req_valid req_ready req_data    | one joint vector
// rsp     | out       | rsp_valid rsp_ready rsp_data    | one frame, four per joint vector
// csr     | in        | csr_valid csr_ready csr_index/data | one register write
//
// from acceptance to the first frame a joint vector passes the input register, the cordic cell chain,
// the geometry stages and the serialiser; throughput is bounded by the four frames sharing the rsp channel
// the whole pipeline halts while a finished joint vector waits for the serialiser to hand
// over the last frame of the previous one
// synchronous reset clears valid state and sets both lengths to 6554; csr is always ready
module serial_arm_forward_kinematics (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  sarmfk_pkg::req_type         req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output sarmfk_pkg::rsp_type         rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  sarmfk_pkg::csr_index_type   csr_index,
   input  logic [15:0]                 csr_data
);
   import sarmfk_pkg::*;

   logic [15:0] link_ff, tool_ff;
   logic        adv, load;

   logic        s0_valid_ff;
   cell_type    s0_ff, s0_in;
   logic signed [16:0] sum;

   logic     chain_valid [CORDIC_STEPS+1];
   cell_type chain_data  [CORDIC_STEPS+1];

   logic       post_valid;
   frames_type post_data;

   logic       ser_valid_ff;
   logic [1:0] ser_cnt_ff;
   frames_type ser_ff;
   logic       last_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= 16'd6554;
         tool_ff <= 16'd6554;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LINK_LENGTH: link_ff <= csr_data;
            CSR_TOOL_LENGTH: tool_ff <= csr_data;
            default: ;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   assign last_beat = ser_valid_ff && rsp_ready && (ser_cnt_ff == 2'd3);
   assign load      = post_valid && (!ser_valid_ff || last_beat);
   assign adv       = !post_valid || load;
   assign req_ready = adv;

   // pitch sum wrapped into plus or minus pi
   always_comb begin
      sum = 17'(req_data.first_pitch) + 17'(req_data.second_pitch);
      if (sum > PI_Q13) sum = sum - TWO_PI_Q13;
      else if (sum < -PI_Q13) sum = sum + TWO_PI_Q13;
      s0_in.lane[0] = fold_lane(req_data.yaw_angle);
      s0_in.lane[1] = fold_lane(req_data.first_pitch);
      s0_in.lane[2] = fold_lane(sum[15:0]);
      s0_in.ext     = req_data.extension;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_valid;
      end
      if (adv) begin
         s0_ff <= s0_in;
      end
   end

   assign chain_valid[0] = s0_valid_ff;
   assign chain_data[0]  = s0_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      sarmfk_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .step      (STEP_W'(i)),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   sarmfk_post u_post (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .link_length (link_ff),
      .tool_length (tool_ff),
      .in_valid    (chain_valid[CORDIC_STEPS]),
      .in_data     (chain_data[CORDIC_STEPS]),
      .out_valid   (post_valid),
      .out_data    (post_data)
   );

   // serialiser: one frame per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
         ser_cnt_ff   <= '0;
      end else if (load) begin
         ser_valid_ff <= 1'b1;
         ser_cnt_ff   <= '0;
      end else if (ser_valid_ff && rsp_ready) begin
         ser_cnt_ff <= ser_cnt_ff + 2'd1;
         if (ser_cnt_ff == 2'd3) begin
            ser_valid_ff <= 1'b0;
         end
      end
      if (load) begin
         ser_ff <= post_data;
      end
   end

   always_comb begin
      rsp_data.frame   = ser_cnt_ff;
      rsp_data.is_last = (ser_cnt_ff == 2'd3);
      rsp_data.pos_x   = ser_ff.pos[ser_cnt_ff].x;
      rsp_data.pos_y   = ser_ff.pos[ser_cnt_ff].y;
      rsp_data.pos_z   = ser_ff.pos[ser_cnt_ff].z;
      rsp_data.cos_yaw = ser_ff.cy;
      rsp_data.sin_yaw = ser_ff.sy;
      if (ser_cnt_ff[1]) begin
         rsp_data.cos_pitch = ser_ff.cq;
         rsp_data.sin_pitch = ser_ff.sq;
      end else begin
         rsp_data.cos_pitch = ser_ff.cb;
         rsp_data.sin_pitch = ser_ff.sb;
      end
   end
   assign rsp_valid = ser_valid_ff;

endmodule

// File: tb/tb.sv
// self-checking testbench for serial_arm_forward_kinematics: directed table then random joint vectors
// depends on sarmfk_pkg and the rtl top level; predicts every frame with its own fixed-point cordic
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sarmfk_pkg::*;

   localparam int N_RANDOM = 410;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_LINK_LENGTH;
   logic [15:0] csr_data = '0;

   always #6 clock = ~clock;

   serial_arm_forward_kinematics i_dut (.*);

   // predictor copy of the registers
   logic [15:0] link_len_q = 16'd6554;
   logic [15:0] tool_len_q = 16'd6554;

   rsp_type frames_due[$];
   int      error_count = 0;
   int      cycle_count = 0;
   bit      hold_rsp = 1'b0;     // long receiver stall
   bit      rsp_calm = 1'b0;     // stretch with no idling

   function automatic longint shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic logic signed [15:0] round_q14(longint v);
      longint r;
      r = (v + (64'sd1 <<< 15)) >>> 16;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return 16'(r);
   endfunction

   function automatic logic signed [19:0] round_pos(longint v);
      longint r;
      r = (v + (64'sd1 <<< 27)) >>> 28;
      if (r > 524287) r = 524287;
      if (r < -524288) r = -524288;
      return 20'(r);
   endfunction

   task automatic rotate(input int ang, output int c, output int s);
      longint atan_tab[24] = '{843314856, 497837829, 263043836, 133525158, 66890614,
         33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
         131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
      longint z, x, y, nx;
      bit flip;
      z = longint'(ang) * 131072;
      x = 652032874;
      y = 0;
      flip = 1'b0;
      if (z > 64'sd1686629713) begin
         z -= 64'sd3373259426;
         flip = 1'b1;
      end else if (z < -64'sd1686629713) begin
         z += 64'sd3373259426;
         flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - shr(y, i);
            y = y + shr(x, i);
            z -= atan_tab[i];
         end else begin
            nx = x + shr(y, i);
            y = y - shr(x, i);
            z += atan_tab[i];
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = round_q14(x);
      s = round_q14(y);
   endtask

   task automatic predict_frames(input req_type j);
      int pitch_sum, cy, sy, cb, sb, cq, sq;
      longint len, tl, base_z, d3, d4, px, py, pz;
      rsp_type f;
      len = longint'(link_len_q);
      tl = longint'(tool_len_q);
      pitch_sum = int'(j.first_pitch) + int'(j.second_pitch);
      if (pitch_sum > 25736) pitch_sum -= 51472;
      else if (pitch_sum < -25736) pitch_sum += 51472;
      rotate(int'(j.yaw_angle), cy, sy);
      rotate(int'(j.first_pitch), cb, sb);
      rotate(pitch_sum, cq, sq);
      base_z = len * (64'sd1 <<< 28);
      d3 = len + longint'(j.extension);
      d4 = 2 * len + longint'(j.extension);
      for (int fr = 0; fr < FRAMES; fr++) begin
         case (fr)
            0: begin
               px = 0; py = 0; pz = base_z;
            end
            1: begin
               px = d3 * sb * cy; py = d3 * sb * sy; pz = base_z + d3 * cb * 16384;
            end
            2: begin
               px = d4 * sb * cy; py = d4 * sb * sy; pz = base_z + d4 * cb * 16384;
            end
            default: begin
               px += tl * sq * cy; py += tl * sq * sy; pz += tl * cq * 16384;
            end
         endcase
         f.frame = 2'(fr);
         f.is_last = (fr == FRAMES - 1);
         f.pos_x = round_pos(px);
         f.pos_y = round_pos(py);
         f.pos_z = round_pos(pz);
         f.cos_yaw = 16'(cy);
         f.sin_yaw = 16'(sy);
         f.cos_pitch = 16'(fr < 2 ? cb : cq);
         f.sin_pitch = 16'(fr < 2 ? sb : sq);
         frames_due.push_back(f);
      end
   endtask

   task automatic report(string what, longint exp_v, longint act_v);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, what, exp_v, act_v);
      error_count++;
   endtask

   // result checking
   always @(posedge clock) begin
      rsp_type e;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frames_due.size() == 0) begin
            $display("%0t: unexpected frame transaction, expected none, actual %p",
                     $realtime, rsp_data);
            error_count++;
         end else begin
            e = frames_due.pop_front();
            if (rsp_data.frame !== e.frame) report("frame", e.frame, rsp_data.frame);
            if (rsp_data.is_last !== e.is_last) report("is_last", e.is_last, rsp_data.is_last);
            if (rsp_data.pos_x !== e.pos_x) report("pos_x", e.pos_x, rsp_data.pos_x);
            if (rsp_data.pos_y !== e.pos_y) report("pos_y", e.pos_y, rsp_data.pos_y);
            if (rsp_data.pos_z !== e.pos_z) report("pos_z", e.pos_z, rsp_data.pos_z);
            if (rsp_data.cos_yaw !== e.cos_yaw) report("cos_yaw", e.cos_yaw, rsp_data.cos_yaw);
            if (rsp_data.sin_yaw !== e.sin_yaw) report("sin_yaw", e.sin_yaw, rsp_data.sin_yaw);
            if (rsp_data.cos_pitch !== e.cos_pitch)
               report("cos_pitch", e.cos_pitch, rsp_data.cos_pitch);
            if (rsp_data.sin_pitch !== e.sin_pitch)
               report("sin_pitch", e.sin_pitch, rsp_data.sin_pitch);
         end
      end
   end

   // receiver: random ready, held low while a long stall is requested and high during a calm stretch
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_rsp) rsp_ready <= 1'b0;
      else if (rsp_calm) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(99) >= 20);
   end

   // long receiver hold-off, counted here
   initial begin
      wait (cycle_count == 2000);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (200) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // valid stays high straight into the next transaction unless the sender idles
   task automatic send_joints(input req_type j, input bit calm);
      if (!calm) begin
         while ($urandom_range(99) < 20) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= j;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_frames(j);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] val);
      req_valid <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_LINK_LENGTH) link_len_q = val;
      else tool_len_q = val;
   endtask

   function automatic logic signed [15:0] rand_angle();
      case ($urandom_range(9))
         0: return 16'($urandom_range(65535));
         1: return 16'sd25736;
         2: return -16'sd25736;
         default: return 16'($signed(17'($urandom_range(51472)) - 17'sd25736));
      endcase
   endfunction

   // directed rows: angles at the extremes, the fold points, wrap of the pitch sum
   req_type directed[] = '{
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd25736, 16'sd0, 16'sd0, 16'sd0},
      '{-16'sd25736, 16'sd25736, 16'sd0, 16'sd0},
      '{16'sd12868, 16'sd12868, 16'sd32767, 16'sd0},
      '{-16'sd12868, -16'sd12868, -16'sd32768, 16'sd0},
      '{16'sd12869, 16'sd12869, 16'sd100, 16'sd12869},
      '{16'sd0, 16'sd25736, 16'sd0, 16'sd25736},
      '{16'sd0, -16'sd25736, 16'sd0, -16'sd25736},
      '{16'sd0, 16'sd20000, 16'sd0, 16'sd10000},
      '{16'sd0, -16'sd20000, 16'sd0, -16'sd10000},
      '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000},
      '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff},
      '{16'shffff, 16'shffff, 16'shffff, 16'shffff},
      '{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa},
      '{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555}
   };
   logic [15:0] lengths[] = '{16'd0, 16'd65535, 16'd1, 16'd6554, 16'd40000};

   initial begin
      req_type j;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // reset lengths: first row fully known at a glance
      send_joints(directed[0], 1'b1);
      foreach (directed[k]) begin
         if (k > 0) send_joints(directed[k], 1'b0);
      end
      // maximal lengths with directed rows 2 to 7, which hold the extension extremes
      write_reg(CSR_LINK_LENGTH, 16'd65535);
      write_reg(CSR_TOOL_LENGTH, 16'd65535);
      for (int k = 0; k < 6; k++) send_joints(directed[k + 2], 1'b0);
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n % 80 == 40) begin
            write_reg(CSR_LINK_LENGTH, lengths[$urandom_range(4)]);
            write_reg(CSR_TOOL_LENGTH, lengths[$urandom_range(4)]);
         end
         // sender pause until all frames are back
         if (n == 200) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (frames_due.size() != 0);
         end
         rsp_calm = (n >= 300 && n < 350);
         j.yaw_angle = rand_angle();
         j.first_pitch = rand_angle();
         j.second_pitch = rand_angle();
         j.extension = 16'($urandom_range(65535));
         send_joints(j, rsp_calm);
      end
      req_valid <= 1'b0;
      rsp_calm = 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: serial_arm_forward_kinematics.f
rtl/sarmfk_pkg.sv
rtl/sarmfk_cordic_cell.sv
rtl/sarmfk_post.sv
rtl/serial_arm_forward_kinematics.sv
tb/tb.sv
